### rtl/ubf_pkg.sv
// ----------------------------------------------------------------------------
// ubf_pkg
// Shared types and constants for the UF2 block framer.
// ----------------------------------------------------------------------------
package ubf_pkg;

    // image size limits and derived widths
    localparam int unsigned MAX_IMAGE_BYTES = 16777216;
    localparam int LEN_W   = 25;                     // image_length register width
    localparam int POS_W   = 22;                     // payload word position
    localparam int SLOT_W  = 5;                      // payload word within a block
    localparam int BLK_W   = POS_W - SLOT_W;         // block number
    localparam int NBLK_W  = LEN_W - 7;              // block total, (len + 255) >> 8
    localparam int IDX_W   = 6;                      // output word within a block

    // stream layout of one 512-byte block
    localparam int HDR_WORDS = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = 6'd63;

    // uf2 constants
    localparam logic [31:0] MAGIC_START0  = 32'h0A324655;
    localparam logic [31:0] MAGIC_START1  = 32'h9E5D5157;
    localparam logic [31:0] MAGIC_END     = 32'h0AB16F30;
    localparam logic [31:0] UF2_FLAGS     = 32'h00002000;
    localparam logic [31:0] PAYLOAD_BYTES = 32'd256;

    // configuration register indexes
    localparam logic [1:0] CFG_FAMILY_ID    = 2'd0;
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_IMAGE_LENGTH = 2'd2;

    // register reset values
    localparam logic [31:0]      RST_FAMILY_ID    = 32'h57755A57;
    localparam logic [31:0]      RST_BASE_ADDRESS = 32'h08010000;
    localparam logic [LEN_W-1:0] RST_IMAGE_LENGTH = 25'd256;

    // one classified payload word, front to back
    typedef struct packed {
        logic [63:0]       word;    // masked payload bytes
        logic [BLK_W-1:0]  blk;     // block number
        logic [SLOT_W-1:0] slot;    // position within the block
        logic              last;    // final word of the image
        logic              close;   // block closes after this word
    } ubf_item_t;

    // back-end sequencer state
    typedef enum logic {
        BK_START,
        BK_CONT
    } bk_state_t;

endpackage

### rtl/uf2_block_framer.sv
// ----------------------------------------------------------------------------
// uf2_block_framer
// Frames a firmware image into 512-byte UF2 blocks of 64 words each.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one 64-bit little-endian image word per request.
//   m_ channel: the UF2 stream, one 64-bit word per request. m_tlast marks the
//   last word caused by an input word; m_tuser[0] marks the end of a block,
//   m_tuser[1] the end of the image.
//   cfg port: family id (0), base address (1), image length (2); write only
//   while the block is idle.
// Timing: an input is first written into the queue; its first output word is
//   then registered in the output stage.
// Throughput: the back end issues one output word per cycle while the output
//   is not stalled; an input word yields one output word, five at the start of
//   a block, 29 when it closes a full block and up to 64 when it ends the image
//   on the first word of a block, two per input word on average over a full block.
// A two-entry queue sits between the input classifier and the word sequencer,
//   so inputs keep flowing while the output stalls until the queue fills.
// Reset clears the image position, the queue and the output stage, and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module uf2_block_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] payload_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] out_word
    output logic        m_tlast,    // last_of_run
    output logic [1:0]  m_tuser,    // [0] block_end, [1] image_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ubf_pkg::*;

    logic [31:0]      family_id_reg;
    logic [31:0]      base_address_reg;
    logic [LEN_W-1:0] image_length_reg;

    logic             q_full, q_push, q_pop, q_head_valid;
    ubf_item_t        q_item, q_head;
    logic [NBLK_W-1:0] nblocks;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            family_id_reg    <= RST_FAMILY_ID;
            base_address_reg <= RST_BASE_ADDRESS;
            image_length_reg <= RST_IMAGE_LENGTH;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FAMILY_ID:    family_id_reg    <= cfg_wdata;
                CFG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                CFG_IMAGE_LENGTH: image_length_reg <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    ubf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .image_length (image_length_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item),
        .nblocks      (nblocks)
    );

    ubf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ubf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .family_id    (family_id_reg),
        .base_address (base_address_reg),
        .nblocks      (nblocks),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

`ifndef SYNTH
    // image end only on a block end
    a_image_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("image end without block end");

    // a block end always closes the run of its input word
    a_block_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("block end not marked last of run");

    // every block end carries the end magic
    a_end_magic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[63:32] == MAGIC_END)
        else $error("block end without end magic");

    // the queue is never popped while empty
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");
`endif

endmodule

### rtl/ubf_front.sv
// ----------------------------------------------------------------------------
// ubf_front
// Accepts payload words, tracks the image position, masks bytes past the
// image length and classifies each word for the back end.
// ----------------------------------------------------------------------------
module ubf_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,     // [63:0] payload_word
    input  logic [ubf_pkg::LEN_W-1:0] image_length,
    input  logic                      q_full,
    output logic                      q_push,
    output ubf_pkg::ubf_item_t        q_item,
    output logic [ubf_pkg::NBLK_W-1:0] nblocks
);
    import ubf_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W:0]     len_plus;
    logic [POS_W-1:0]   total_words;
    logic [POS_W:0]     pos_plus;
    logic [LEN_W-1:0]   start_byte;
    logic [LEN_W-1:0]   remain;
    logic               is_last;
    logic [63:0]        masked;
    logic [LEN_W:0]     nblk_sum;

    // clamp the length into its legal range
    always_comb begin
        if (image_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (image_length > LEN_W'(MAX_IMAGE_BYTES)) begin
            eff_len = LEN_W'(MAX_IMAGE_BYTES);
        end else begin
            eff_len = image_length;
        end
    end

    // word and block totals
    assign len_plus    = {1'b0, eff_len} + (LEN_W+1)'(7);
    assign total_words = POS_W'(len_plus >> 3);
    assign nblk_sum    = {1'b0, eff_len} + (LEN_W+1)'(255);
    assign nblocks     = NBLK_W'(nblk_sum >> 8);

    assign pos_plus   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign is_last    = pos_plus >= {1'b0, total_words};
    assign start_byte = LEN_W'({pos_reg, 3'b000});
    assign remain     = eff_len - start_byte;

    // zero the bytes past the image end
    always_comb begin
        masked = s_tdata;
        if (eff_len <= start_byte) begin
            masked = '0;
        end else if (remain < LEN_W'(8)) begin
            for (int b = 0; b < 8; b++) begin
                if (3'(b) >= remain[2:0]) begin
                    masked[8*b +: 8] = 8'h00;
                end
            end
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.word  = masked;
        q_item.blk   = pos_reg[POS_W-1:SLOT_W];
        q_item.slot  = pos_reg[SLOT_W-1:0];
        q_item.last  = is_last;
        q_item.close = is_last || (pos_reg[SLOT_W-1:0] == '1);
    end

    // position advances per request, wraps after the final word
    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            pos_next = is_last ? '0 : pos_plus[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

### rtl/ubf_queue.sv
// ----------------------------------------------------------------------------
// ubf_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module ubf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ubf_pkg::ubf_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output ubf_pkg::ubf_item_t head
);
    import ubf_pkg::*;

    ubf_item_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/ubf_back.sv
// ----------------------------------------------------------------------------
// ubf_back
// Expands each classified word into header, payload, padding and tail
// words, one per cycle while the output is free, into a registered output stage.
// ----------------------------------------------------------------------------
module ubf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  ubf_pkg::ubf_item_t         head,
    output logic                       pop,
    input  logic [31:0]                family_id,
    input  logic [31:0]                base_address,
    input  logic [ubf_pkg::NBLK_W-1:0] nblocks,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,    // [63:0] out_word
    output logic                       m_tlast,    // last_of_run
    output logic [1:0]                 m_tuser     // [0] block_end, [1] image_end
);
    import ubf_pkg::*;

    bk_state_t        state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pay_idx, start_idx, stop_idx, cur_idx;
    logic             out_free, emit, done;
    logic [31:0]      addr;
    logic [63:0]      word;
    logic             blk_end;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg;
    logic             m_tlast_reg;
    logic [1:0]       m_tuser_reg;

    // where this word's run starts and stops within the block
    assign pay_idx   = IDX_W'(HDR_WORDS) + IDX_W'(head.slot);
    assign start_idx = (head.slot == '0) ? '0 : pay_idx;
    assign stop_idx  = head.close ? LAST_IDX : pay_idx;
    assign cur_idx   = (state_reg == BK_CONT) ? idx_reg : start_idx;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = head_valid && out_free;
    assign done     = cur_idx == stop_idx;

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (emit) begin
            state_next = done ? BK_START : BK_CONT;
            idx_next   = cur_idx + IDX_W'(1);
        end
    end

    // word selection and pop
    assign addr    = base_address + 32'({head.blk, 8'h00});
    assign blk_end = cur_idx == LAST_IDX;
    always_comb begin
        pop = emit && done;
        if (cur_idx == IDX_W'(0)) begin
            word = {MAGIC_START1, MAGIC_START0};
        end else if (cur_idx == IDX_W'(1)) begin
            word = {addr, UF2_FLAGS};
        end else if (cur_idx == IDX_W'(2)) begin
            word = {32'(head.blk), PAYLOAD_BYTES};
        end else if (cur_idx == IDX_W'(3)) begin
            word = {family_id, 32'(nblocks)};
        end else if (cur_idx == pay_idx) begin
            word = head.word;
        end else if (blk_end) begin
            word = {MAGIC_END, 32'h0};
        end else begin
            word = '0;
        end
    end

    // output register valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_START;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= word;
            m_tlast_reg <= done;
            m_tuser_reg <= {blk_end && head.last, blk_end};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### tb/uf2_block_framer_checker.sv
// ----------------------------------------------------------------------------
// uf2_block_framer_checker
// Watches the payload, UF2 stream and register write ports of the framer. It
// keeps its own copy of the registers and the image position, builds the
// 64-word blocks that each accepted payload word should cause, and compares
// every accepted stream word against the oldest word still expected.
// ----------------------------------------------------------------------------
module uf2_block_framer_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,    // [63:0] payload_word
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [63:0]       m_tdata,    // [63:0] out_word
    input  logic              m_tlast,    // last_of_run
    input  logic [1:0]        m_tuser,    // [0] block_end, [1] image_end
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    output int unsigned       pending_words,
    output int unsigned       mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ubf_pkg::*;

    // one expected word of the uf2 stream
    typedef struct packed {
        logic [63:0] word;
        logic        run_last;
        logic        blk_end;
        logic        img_end;
    } stream_word_t;

    stream_word_t uf2_stream_q[$];

    // shadow registers and image position
    logic [31:0]      family_r;
    logic [31:0]      base_r;
    logic [LEN_W-1:0] length_r;
    logic [POS_W-1:0] word_pos;

    task automatic queue_word(input logic [63:0] w, input logic run_last,
                              input logic blk_end, input logic img_end);
        stream_word_t e;
        e.word     = w;
        e.run_last = run_last;
        e.blk_end  = blk_end;
        e.img_end  = img_end;
        uf2_stream_q = {uf2_stream_q, e};
    endtask

    // expected stream words for one payload word at the current position
    task automatic frame_payload_word(input logic [63:0] data);
        int unsigned len;
        int unsigned total_words;
        int unsigned nblocks;
        int unsigned p;
        int unsigned slot;
        int unsigned blk;
        int unsigned start;
        int unsigned nb;
        int unsigned k;
        logic        last;
        logic        closes;
        logic [63:0] w;
        logic [31:0] addr;

        // out-of-range lengths are clamped
        len = 32'(length_r);
        if (len == 0)
            len = 1;
        if (len > MAX_IMAGE_BYTES)
            len = MAX_IMAGE_BYTES;
        total_words = (len + 7) >> 3;
        nblocks     = (len + 255) >> 8;
        p           = 32'(word_pos);
        slot        = p & 31;
        blk         = p >> 5;
        last        = (p + 1 >= total_words);
        closes      = last || (slot == 31);
        start       = p * 8;

        // bytes past the image end read as zero
        w = data;
        if (len <= start) begin
            w = '0;
        end else if (len - start < 8) begin
            nb = len - start;
            w  = w & ((64'd1 << (8 * nb)) - 64'd1);
        end

        // block header on the first word of a block
        if (slot == 0) begin
            addr = base_r + (blk << 8);
            queue_word({MAGIC_START1, MAGIC_START0}, 1'b0, 1'b0, 1'b0);
            queue_word({addr, UF2_FLAGS}, 1'b0, 1'b0, 1'b0);
            queue_word({blk, PAYLOAD_BYTES}, 1'b0, 1'b0, 1'b0);
            queue_word({family_r, nblocks}, 1'b0, 1'b0, 1'b0);
        end

        queue_word(w, !closes, 1'b0, 1'b0);

        // zero padding, zero tail and end magic when the block closes
        if (closes) begin
            for (k = slot + 1; k < 32; k++)
                queue_word('0, 1'b0, 1'b0, 1'b0);
            for (k = 0; k < 27; k++)
                queue_word('0, 1'b0, 1'b0, 1'b0);
            queue_word({MAGIC_END, 32'h0}, 1'b1, 1'b1, last);
        end

        word_pos = last ? '0 : POS_W'(p + 1);
    endtask

    // register writes, prediction and comparison at each rising edge
    always @(posedge aclk) begin : monitor
        stream_word_t exp_w;
        if (!aresetn) begin
            family_r       = RST_FAMILY_ID;
            base_r         = RST_BASE_ADDRESS;
            length_r       = RST_IMAGE_LENGTH;
            word_pos       = '0;
            mismatch_count = 0;
            uf2_stream_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FAMILY_ID:    family_r = cfg_wdata;
                    CFG_BASE_ADDRESS: base_r   = cfg_wdata;
                    CFG_IMAGE_LENGTH: length_r = cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                frame_payload_word(s_tdata);
            if (m_tvalid && m_tready) begin
                if (uf2_stream_q.size() == 0) begin
                    $error("unexpected stream word %h", m_tdata);
                    mismatch_count++;
                end else begin
                    exp_w = uf2_stream_q.pop_front();
                    if (m_tdata !== exp_w.word) begin
                        $error("out_word: expected %h, actual %h", exp_w.word, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== exp_w.run_last) begin
                        $error("last_of_run: expected %b, actual %b", exp_w.run_last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== exp_w.blk_end) begin
                        $error("block_end: expected %b, actual %b", exp_w.blk_end, m_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_tuser[1] !== exp_w.img_end) begin
                        $error("image_end: expected %b, actual %b", exp_w.img_end, m_tuser[1]);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_words = uf2_stream_q.size();
    end

endmodule

### tb/uf2_block_framer_test.sv
// ----------------------------------------------------------------------------
// uf2_block_framer_test
// Drives payload words and register writes into the UF2 block framer under
// random stalls on both channels. A short directed sequence covers register
// defaults, clamped lengths, length changes in the middle of an image and
// byte masking; random images of mixed sizes follow. The checker predicts
// and compares; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module uf2_block_framer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ubf_pkg::*;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;    // no register at this index
    localparam int unsigned WORD_TARGET = 420;
    localparam int unsigned QUIET_LIMIT = 3000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int unsigned pending_words;
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    uf2_block_framer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    uf2_block_framer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // stream receiver stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any request or register write
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // payload value with the extremes now and then
    function automatic logic [63:0] pick_payload();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // family id or base address value with the extremes now and then
    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(4))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return 32'hFFFFFF00;
            default: return $urandom;
        endcase
    endfunction

    // payload words in an image of the given length register value
    function automatic int unsigned image_words(input logic [LEN_W-1:0] len);
        int unsigned eff;
        eff = 32'(len);
        if (eff == 0)
            eff = 1;
        if (eff > MAX_IMAGE_BYTES)
            eff = MAX_IMAGE_BYTES;
        return (eff + 7) / 8;
    endfunction

    // one payload request, idle and stall settings follow the run phase
    task automatic send_word(input logic [63:0] w);
        if (words_sent < WORD_TARGET / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 78;
        end else if (words_sent < 2 * WORD_TARGET / 3) begin
            send_idle_pct = 78;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_words(input int unsigned n);
        repeat (n) send_word(pick_payload());
    endtask

    // register write once every expected stream word has come out
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        s_tvalid = 1'b0;
        while (pending_words != 0)
            @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // length write with junk above the register width
    task automatic write_length(input logic [LEN_W-1:0] len);
        cfg_write(CFG_IMAGE_LENGTH, {7'($urandom), len});
    endtask

    // one random image, sometimes cut short by a length change
    task automatic run_random_image();
        int unsigned     mode;
        int unsigned     k;
        int unsigned     nw;
        logic [LEN_W-1:0] len;
        if ($urandom_range(2) == 0)
            cfg_write(CFG_FAMILY_ID, pick_reg_value());
        if ($urandom_range(2) == 0)
            cfg_write(CFG_BASE_ADDRESS, pick_reg_value());
        mode = $urandom_range(9);
        if (mode == 0) begin
            // large or oversized image, then a new length part way through
            case ($urandom_range(2))
                0:       len = LEN_W'(MAX_IMAGE_BYTES);
                1:       len = '1;
                default: len = LEN_W'($urandom_range(MAX_IMAGE_BYTES / 2, 33554431));
            endcase
            write_length(len);
            k = $urandom_range(1, 40);
            send_words(k);
            len = LEN_W'($urandom_range(0, 8 * k + 100));
            write_length(len);
            nw = image_words(len);
            send_words(nw > k ? nw - k : 1);
        end else begin
            if (mode == 1) begin
                case ($urandom_range(5))
                    0:       len = LEN_W'(0);
                    1:       len = LEN_W'(1);
                    2:       len = LEN_W'(8);
                    3:       len = LEN_W'(256);
                    4:       len = LEN_W'(257);
                    default: len = LEN_W'(512);
                endcase
            end else if (mode < 6) begin
                len = LEN_W'($urandom_range(1, 264));
            end else begin
                len = LEN_W'($urandom_range(265, 1024));
            end
            write_length(len);
            send_words(image_words(len));
        end
    endtask

    // stimulus and verdict
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        words_sent    = 0;
        send_idle_pct = 18;
        recv_idle_pct = 78;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // register defaults on the first block header
        send_word(64'h0);
        send_word('1);
        cfg_write(CFG_UNUSED, 32'hFFFFFFFF);

        // zero length acts as one byte and closes the image in progress
        cfg_write(CFG_IMAGE_LENGTH, 32'h0);
        send_word('1);
        // next request starts a new one-byte image
        send_word('1);

        // nine bytes, second word masked to one byte, top address
        cfg_write(CFG_FAMILY_ID, 32'hFFFFFFFF);
        cfg_write(CFG_BASE_ADDRESS, 32'hFFFFFFFF);
        cfg_write(CFG_IMAGE_LENGTH, 32'd9);
        send_word('1);
        send_word('1);

        // oversized length clamps, then shrinks below the current position
        cfg_write(CFG_FAMILY_ID, 32'h0);
        cfg_write(CFG_BASE_ADDRESS, 32'hFFFFFF00);
        cfg_write(CFG_IMAGE_LENGTH, 32'hFFFFFFFF);
        send_words(3);
        cfg_write(CFG_IMAGE_LENGTH, 32'd16);
        send_word('1);

        // twenty bytes, last word keeps four bytes
        cfg_write(CFG_BASE_ADDRESS, 32'h0);
        cfg_write(CFG_IMAGE_LENGTH, 32'd20);
        send_word('1);
        send_word('1);
        send_word('1);

        // random images
        while (words_sent < WORD_TARGET)
            run_random_image();

        // drain
        s_tvalid = 1'b0;
        while (pending_words != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);

        if (mismatch_count == 0 && pending_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
